### src/dfst_pkg.sv
`timescale 1ns / 1ps
package dfst_pkg;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic [11:0]        texel_address;
        logic [31:0]        texel_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] color_red;
        logic [15:0] color_green;
        logic [15:0] color_blue;
        logic [14:0] color_alpha;
    } t_out_item;

    localparam logic OPC_SHADE = 1'b0;
    localparam logic OPC_TEXEL = 1'b1;

    localparam logic [1:0] SRC_DIFFUSE = 2'd0;
    localparam logic [1:0] SRC_TEXTURE = 2'd1;
    localparam logic [1:0] SRC_EMPTY   = 2'd2;

    localparam logic [2:0] CFG_LIGHT    = 3'd0;
    localparam logic [2:0] CFG_CAMERA   = 3'd1;
    localparam logic [2:0] CFG_DIFFUSE  = 3'd2;
    localparam logic [2:0] CFG_SOURCE   = 3'd3;
    localparam logic [2:0] CFG_DOUBLE   = 3'd4;
    localparam logic [2:0] CFG_WIDTH    = 3'd5;
    localparam logic [2:0] CFG_HEIGHT   = 3'd6;
    localparam logic [2:0] CFG_CHANNELS = 3'd7;

    // square root: one result bit per stage; division: one quotient bit per stage
    localparam int SQ_STEPS  = 29;
    localparam int DIV_STEPS = 15;
    localparam int NORM_LAT  = SQ_STEPS + DIV_STEPS + 4;

    localparam logic [14:0] ONE_Q14     = 15'd16384;
    localparam logic [14:0] AMBIENT_Q14 = 15'd3277;
    localparam logic [22:0] BYTE_RECIP  = 23'd4210753;

    // round(b * 16384 / 255) via reciprocal multiply
    function automatic logic [14:0] byte_q14(input logic [7:0] b);
        logic [21:0] x;
        logic [44:0] p;
        x = {b, 14'd0} + 22'd127;
        p = 45'(x) * 45'(BYTE_RECIP);
        return p[44:30];
    endfunction

endpackage

### src/dfst_norm.sv
`timescale 1ns / 1ps
module dfst_norm (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2:0][16:0] i_vec,
    output logic [2:0][15:0] o_vec
);
    import dfst_pkg::*;

    // stage A: magnitude and square
    logic [2:0][15:0] n_a_mag;
    logic [2:0]       n_a_sgn;
    logic [2:0][31:0] n_a_sq;
    logic [2:0][15:0] r_a_mag;
    logic [2:0]       r_a_sgn;
    logic [2:0][31:0] r_a_sq;

    always_comb begin
        logic [16:0] v_abs;
        v_abs = '0;
        for (int k = 0; k < 3; k++) begin
            n_a_sgn[k] = i_vec[k][16];
            v_abs      = i_vec[k][16] ? 17'(-i_vec[k]) : i_vec[k];
            n_a_mag[k] = v_abs[15:0];
            n_a_sq[k]  = 32'(n_a_mag[k]) * 32'(n_a_mag[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag <= n_a_mag;
            r_a_sgn <= n_a_sgn;
            r_a_sq  <= n_a_sq;
        end
    end

    // stage B: sum of squares
    logic [33:0]      r_b_s;
    logic [2:0][15:0] r_b_mag;
    logic [2:0]       r_b_sgn;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_s   <= 34'(r_a_sq[0]) + 34'(r_a_sq[1]) + 34'(r_a_sq[2]);
            r_b_mag <= r_a_mag;
            r_b_sgn <= r_a_sgn;
        end
    end

    // square root of s * 2^24, one bit per stage
    logic [30:0]      r_q_rem  [SQ_STEPS];
    logic [28:0]      r_q_root [SQ_STEPS];
    logic [33:0]      r_q_x    [SQ_STEPS];
    logic [2:0][15:0] r_q_mag  [SQ_STEPS];
    logic [2:0]       r_q_sgn  [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        logic [30:0]      w_rem;
        logic [28:0]      w_root;
        logic [33:0]      w_x;
        logic [2:0][15:0] w_mag;
        logic [2:0]       w_sgn;
        logic [32:0]      w_rem2;
        logic [32:0]      w_trial;

        if (j == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_x    = r_b_s;
            assign w_mag  = r_b_mag;
            assign w_sgn  = r_b_sgn;
        end else begin : g_next
            assign w_rem  = r_q_rem[j-1];
            assign w_root = r_q_root[j-1];
            assign w_x    = r_q_x[j-1];
            assign w_mag  = r_q_mag[j-1];
            assign w_sgn  = r_q_sgn[j-1];
        end

        assign w_rem2  = {w_rem, w_x[33:32]};
        assign w_trial = {2'b00, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem2 >= w_trial) begin
                    r_q_rem[j]  <= 31'(w_rem2 - w_trial);
                    r_q_root[j] <= {w_root[27:0], 1'b1};
                end else begin
                    r_q_rem[j]  <= w_rem2[30:0];
                    r_q_root[j] <= {w_root[27:0], 1'b0};
                end
                r_q_x[j]   <= {w_x[31:0], 2'b00};
                r_q_mag[j] <= w_mag;
                r_q_sgn[j] <= w_sgn;
            end
        end
    end

    // dividend setup: (m << 26) + (r >> 1)
    logic [2:0][28:0] r_n_rem;
    logic [2:0][14:0] r_n_lo;
    logic [28:0]      r_n_r;
    logic [2:0]       r_n_sgn;
    logic             r_n_zero;

    always_ff @(posedge i_clk) begin
        logic [42:0] v_num;
        logic [28:0] v_r;
        if (i_en) begin
            v_r = r_q_root[SQ_STEPS-1];
            for (int k = 0; k < 3; k++) begin
                v_num      = {1'b0, r_q_mag[SQ_STEPS-1][k], 26'd0} + {15'd0, v_r[28:1]};
                r_n_rem[k] <= {1'b0, v_num[42:15]};
                r_n_lo[k]  <= v_num[14:0];
            end
            r_n_r    <= v_r;
            r_n_sgn  <= r_q_sgn[SQ_STEPS-1];
            r_n_zero <= (v_r == '0);
        end
    end

    // restoring division, one quotient bit per stage
    logic [2:0][28:0] r_d_rem  [DIV_STEPS];
    logic [2:0][14:0] r_d_lo   [DIV_STEPS];
    logic [28:0]      r_d_r    [DIV_STEPS];
    logic [2:0]       r_d_sgn  [DIV_STEPS];
    logic             r_d_zero [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [2:0][28:0] w_rem;
        logic [2:0][14:0] w_lo;
        logic [28:0]      w_r;
        logic [2:0]       w_sgn;
        logic             w_zero;

        if (j == 0) begin : g_first
            assign w_rem  = r_n_rem;
            assign w_lo   = r_n_lo;
            assign w_r    = r_n_r;
            assign w_sgn  = r_n_sgn;
            assign w_zero = r_n_zero;
        end else begin : g_next
            assign w_rem  = r_d_rem[j-1];
            assign w_lo   = r_d_lo[j-1];
            assign w_r    = r_d_r[j-1];
            assign w_sgn  = r_d_sgn[j-1];
            assign w_zero = r_d_zero[j-1];
        end

        always_ff @(posedge i_clk) begin
            logic [29:0] v_rem2;
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    v_rem2 = {w_rem[k], w_lo[k][14]};
                    if (v_rem2 >= {1'b0, w_r}) begin
                        r_d_rem[j][k] <= 29'(v_rem2 - {1'b0, w_r});
                        r_d_lo[j][k]  <= {w_lo[k][13:0], 1'b1};
                    end else begin
                        r_d_rem[j][k] <= v_rem2[28:0];
                        r_d_lo[j][k]  <= {w_lo[k][13:0], 1'b0};
                    end
                end
                r_d_r[j]    <= w_r;
                r_d_sgn[j]  <= w_sgn;
                r_d_zero[j] <= w_zero;
            end
        end
    end

    // clamp to one and apply sign
    logic [2:0][15:0] r_o_vec;

    always_ff @(posedge i_clk) begin
        logic [14:0] v_q;
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                v_q = r_d_lo[DIV_STEPS-1][k];
                if (v_q > ONE_Q14) v_q = ONE_Q14;
                if (r_d_zero[DIV_STEPS-1]) begin
                    r_o_vec[k] <= '0;
                end else if (r_d_sgn[DIV_STEPS-1][k]) begin
                    r_o_vec[k] <= 16'(-{1'b0, v_q});
                end else begin
                    r_o_vec[k] <= {1'b0, v_q};
                end
            end
        end
    end

    assign o_vec = r_o_vec;

endmodule

### src/diffuse_fragment_shader_textured.sv
// Lambert diffuse fragment shader with nearest-texel texture lookup.
// Results leave through the output register; most of the pipeline depth lies in
// the 29-stage square root and 15-stage divider of the normalisers.
// Throughput: one item per cycle, fully pipelined; a full skid register stalls the whole pipe.
// Texel writes occupy one slot and give no result.
// Synchronous active-low reset clears valid bits and config; texel memory is not cleared.
`timescale 1ns / 1ps
module diffuse_fragment_shader_textured #(
    parameter int TEX_MAX_DIM = 64,
    parameter int TEX_WORDS   = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dfst_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dfst_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_wdata
);
    import dfst_pkg::*;

    localparam int AW  = (TEX_WORDS > 1) ? $clog2(TEX_WORDS) : 1;
    localparam int DLY = NORM_LAT - 4;

    typedef struct packed {
        logic             wr;
        logic [2:0][16:0] pc;
        logic [3:0][14:0] col;
    } t_dly;

    // configuration
    logic [47:0] r_light;
    logic [47:0] r_cam;
    logic [31:0] r_diffuse;
    logic [1:0]  r_src;
    logic        r_ds;
    logic [6:0]  r_tw;
    logic [6:0]  r_th;
    logic [2:0]  r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light   <= '0;
            r_cam     <= '0;
            r_diffuse <= 32'hFFFF_FFFF;
            r_src     <= SRC_DIFFUSE;
            r_ds      <= 1'b0;
            r_tw      <= 7'd64;
            r_th      <= 7'd64;
            r_ch      <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIGHT:    r_light   <= i_cfg_wdata;
                CFG_CAMERA:   r_cam     <= i_cfg_wdata;
                CFG_DIFFUSE:  r_diffuse <= i_cfg_wdata[31:0];
                CFG_SOURCE:   r_src     <= i_cfg_wdata[1:0];
                CFG_DOUBLE:   r_ds      <= i_cfg_wdata[0];
                CFG_WIDTH:    r_tw      <= i_cfg_wdata[6:0];
                CFG_HEIGHT:   r_th      <= i_cfg_wdata[6:0];
                CFG_CHANNELS: r_ch      <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_skid_v;
    assign en         = !r_skid_v;
    assign o_in_ready = en;

    // valid chain
    logic           r_s0_v, r_t1_v, r_t2_v, r_t3_v, r_t4_v;
    logic [DLY-1:0] r_dl_v;
    logic           r_p1_v, r_p2_v, r_p3_v, r_f_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
            r_dl_v <= '0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_f_v  <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in_valid;
            r_t1_v <= r_s0_v;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v;
            r_t4_v <= r_t3_v;
            r_dl_v <= {r_dl_v[DLY-2:0], r_t4_v};
            r_p1_v <= r_dl_v[DLY-1];
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_f_v  <= r_p3_v;
        end
    end

    // stage 0: input register, light and camera offsets
    logic             r_s0_wr;
    logic [2:0][16:0] r_s0_ld;
    logic [2:0][16:0] r_s0_nrm;
    logic [2:0][16:0] r_s0_pc;
    logic [11:0]      r_s0_fu, r_s0_fv;
    logic [11:0]      r_s0_waddr;
    logic [31:0]      r_s0_wval;

    logic [2:0][15:0] w_pos;
    assign w_pos = {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s0_ld[k] <= {r_light[16*k+15], r_light[16*k +: 16]}
                            - {w_pos[k][15], w_pos[k]};
                r_s0_pc[k] <= {w_pos[k][15], w_pos[k]}
                            - {r_cam[16*k+15], r_cam[16*k +: 16]};
            end
            r_s0_nrm[0] <= {i_in_data.normal_x[15], i_in_data.normal_x};
            r_s0_nrm[1] <= {i_in_data.normal_y[15], i_in_data.normal_y};
            r_s0_nrm[2] <= {i_in_data.normal_z[15], i_in_data.normal_z};
            r_s0_wr     <= (i_in_data.opcode == OPC_TEXEL);
            r_s0_fu     <= i_in_data.tex_u[11:0];
            r_s0_fv     <= i_in_data.tex_v[11:0];
            r_s0_waddr  <= i_in_data.texel_address;
            r_s0_wval   <= i_in_data.texel_value;
        end
    end

    // texture size clamp
    logic [6:0] w_dw, w_dh;
    always_comb begin
        w_dw = r_tw;
        w_dh = r_th;
        if (r_tw == '0) w_dw = 7'd1;
        else if (int'(r_tw) > TEX_MAX_DIM) w_dw = 7'(TEX_MAX_DIM);
        if (r_th == '0) w_dh = 7'd1;
        else if (int'(r_th) > TEX_MAX_DIM) w_dh = 7'(TEX_MAX_DIM);
    end

    // stage 1: texel column and row
    logic             r_t1_wr;
    logic [2:0][16:0] r_t1_pc;
    logic [6:0]       r_t1_tx, r_t1_ty;
    logic [11:0]      r_t1_waddr;
    logic [31:0]      r_t1_wval;

    always_ff @(posedge i_clk) begin
        logic [18:0] v_pu, v_pv;
        if (en) begin
            v_pu       = 19'(r_s0_fu) * 19'(w_dw - 7'd1) + 19'd2048;
            v_pv       = 19'(r_s0_fv) * 19'(w_dh - 7'd1) + 19'd2048;
            r_t1_tx    <= v_pu[18:12];
            r_t1_ty    <= v_pv[18:12];
            r_t1_wr    <= r_s0_wr;
            r_t1_pc    <= r_s0_pc;
            r_t1_waddr <= r_s0_waddr;
            r_t1_wval  <= r_s0_wval;
        end
    end

    // stage 2: word address
    logic             r_t2_wr;
    logic [2:0][16:0] r_t2_pc;
    logic [13:0]      r_t2_addr;
    logic [11:0]      r_t2_waddr;
    logic [31:0]      r_t2_wval;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t2_addr  <= 14'(r_t1_ty) * 14'(w_dw) + 14'(r_t1_tx);
            r_t2_wr    <= r_t1_wr;
            r_t2_pc    <= r_t1_pc;
            r_t2_waddr <= r_t1_waddr;
            r_t2_wval  <= r_t1_wval;
        end
    end

    // stage 3: texel memory access
    logic [31:0]    r_mem [TEX_WORDS];
    logic [31:0]    r_t3_rd;
    logic           r_t3_inr;
    logic           r_t3_wr;
    logic [2:0][16:0] r_t3_pc;
    logic [AW+11:0] w_wa;
    logic [AW+13:0] w_ra;
    logic           w_wr_inr;

    assign w_wa     = (AW+12)'(r_t2_waddr);
    assign w_ra     = (AW+14)'(r_t2_addr);
    assign w_wr_inr = (32'(r_t2_waddr) < 32'(TEX_WORDS));

    always_ff @(posedge i_clk) begin
        if (en && r_t2_v && r_t2_wr && w_wr_inr) begin
            r_mem[w_wa[AW-1:0]] <= r_t2_wval;
        end
        if (en) begin
            r_t3_rd <= r_mem[w_ra[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t3_inr <= (32'(r_t2_addr) < 32'(TEX_WORDS));
            r_t3_wr  <= r_t2_wr;
            r_t3_pc  <= r_t2_pc;
        end
    end

    // stage 4: base colour
    logic [3:0][14:0] n_col;
    logic [3:0][14:0] r_t4_col;
    logic             r_t4_wr;
    logic [2:0][16:0] r_t4_pc;

    always_comb begin
        logic [31:0] v_word;
        v_word = r_t3_inr ? r_t3_rd : '0;
        n_col  = '0;
        case (r_src)
            SRC_DIFFUSE: begin
                for (int k = 0; k < 4; k++) n_col[k] = byte_q14(r_diffuse[8*k +: 8]);
            end
            SRC_TEXTURE: begin
                n_col[3] = ONE_Q14;
                if (r_ch >= 3'd1 && r_ch <= 3'd4) begin
                    n_col[0] = byte_q14(v_word[7:0]);
                    if (r_ch >= 3'd2) n_col[1] = byte_q14(v_word[15:8]);
                    if (r_ch >= 3'd3) n_col[2] = byte_q14(v_word[23:16]);
                    if (r_ch >= 3'd4) n_col[3] = byte_q14(v_word[31:24]);
                end
            end
            SRC_EMPTY: n_col = '0;
            default:   n_col = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t4_col <= n_col;
            r_t4_wr  <= r_t3_wr;
            r_t4_pc  <= r_t3_pc;
        end
    end

    // delay line alongside the normalisers
    t_dly r_dl [DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0] <= '{wr: r_t4_wr, pc: r_t4_pc, col: r_t4_col};
            for (int k = 1; k < DLY; k++) r_dl[k] <= r_dl[k-1];
        end
    end

    logic [2:0][15:0] w_n, w_l;

    dfst_norm u_nrm (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (r_s0_nrm),
        .o_vec (w_n)
    );

    dfst_norm u_lgt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (r_s0_ld),
        .o_vec (w_l)
    );

    // P1: facing and lighting products
    logic signed [32:0] r_p1_fp [3];
    logic signed [31:0] r_p1_lp [3];
    logic               r_p1_wr;
    logic [3:0][14:0]   r_p1_col;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_p1_fp[k] <= 33'($signed(w_n[k])) * 33'($signed(r_dl[DLY-1].pc[k]));
                r_p1_lp[k] <= 32'($signed(w_n[k])) * 32'($signed(w_l[k]));
            end
            r_p1_wr  <= r_dl[DLY-1].wr;
            r_p1_col <= r_dl[DLY-1].col;
        end
    end

    // P2: sums and flip decision
    logic               r_p2_flip;
    logic signed [33:0] r_p2_dl;
    logic               r_p2_wr;
    logic [3:0][14:0]   r_p2_col;

    always_ff @(posedge i_clk) begin
        logic signed [34:0] v_s;
        if (en) begin
            v_s       = 35'(r_p1_fp[0]) + 35'(r_p1_fp[1]) + 35'(r_p1_fp[2]);
            r_p2_flip <= r_ds && (v_s > 35'sd0);
            r_p2_dl   <= 34'(r_p1_lp[0]) + 34'(r_p1_lp[1]) + 34'(r_p1_lp[2]);
            r_p2_wr   <= r_p1_wr;
            r_p2_col  <= r_p1_col;
        end
    end

    // P3: light factor
    logic [14:0]      r_p3_fac;
    logic             r_p3_wr;
    logic [3:0][14:0] r_p3_col;

    always_ff @(posedge i_clk) begin
        logic signed [34:0] v_d;
        logic [34:0]        v_dr;
        logic [14:0]        v_q;
        if (en) begin
            v_d = r_p2_flip ? -35'(r_p2_dl) : 35'(r_p2_dl);
            v_dr = 35'(v_d) + 35'd8192;
            if (v_d <= 35'sd0) v_q = '0;
            else if (v_dr[34:14] > 21'(ONE_Q14)) v_q = ONE_Q14;
            else v_q = v_dr[28:14];
            r_p3_fac <= v_q + AMBIENT_Q14;
            r_p3_wr  <= r_p2_wr;
            r_p3_col <= r_p2_col;
        end
    end

    // F: channel scale and saturate
    t_out_item r_f_res;
    logic      r_f_wr;

    always_ff @(posedge i_clk) begin
        logic [30:0]      v_p;
        logic [2:0][15:0] v_c;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                v_p = 31'(30'(r_p3_fac) * 30'(r_p3_col[k])) + 31'd8192;
                v_c[k] = v_p[30] ? 16'hFFFF : v_p[29:14];
            end
            r_f_res.color_red   <= v_c[0];
            r_f_res.color_green <= v_c[1];
            r_f_res.color_blue  <= v_c[2];
            r_f_res.color_alpha <= r_p3_col[3];
            r_f_wr              <= r_p3_wr;
        end
    end

    // output register and skid
    logic      fin_v;
    logic      r_out_v;
    t_out_item r_out;
    t_out_item r_skid;

    assign fin_v = r_f_v && !r_f_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_out_ready) begin
            r_out_v <= fin_v;
            r_out   <= r_f_res;
        end else if (fin_v) begin
            r_skid_v <= 1'b1;
            r_skid   <= r_f_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds data while output register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_out_ready) |=> (!r_skid_v && r_out_v))
        else $error("skid not drained after output transfer");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_out_ready) |=> r_out_v)
        else $error("pending result dropped");

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.color_alpha <= ONE_Q14))
        else $error("alpha above one");

endmodule

### test/dfst_checker.sv
`timescale 1ns / 1ps
module dfst_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  dfst_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  dfst_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_wdata,
    output int                  o_pending,
    output int                  o_errors
);
    import dfst_pkg::*;

    localparam int TEX_WORDS_TB = 4096;
    localparam int MAX_DIM_TB   = 64;

    typedef logic signed [63:0] t_vec3 [3];

    logic [47:0] light_pos, camera_pos;
    logic [31:0] diffuse_rgba;
    logic [1:0]  colour_sel;
    logic        two_sided;
    logic [6:0]  tex_w, tex_h;
    logic [2:0]  tex_ch;
    logic [31:0] texels [TEX_WORDS_TB];
    t_out_item   expected_colours [$];
    int          errors;

    assign o_pending = expected_colours.size();
    assign o_errors  = errors;

    initial begin
        errors = 0;
        for (int i = 0; i < TEX_WORDS_TB; i++) texels[i] = '0;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void unit_vector(input t_vec3 v, output t_vec3 o);
        logic [63:0] s, r, m, q;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m = v[i] < 0 ? -v[i] : v[i];
            s += m * m;
        end
        if (s == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        r = int_sqrt(s << 24);
        for (int i = 0; i < 3; i++) begin
            m = v[i] < 0 ? -v[i] : v[i];
            q = ((m << 26) + (r >> 1)) / r;
            if (q > 16384) q = 16384;
            o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic [63:0] byte_to_q14(input logic [7:0] b);
        return (64'(b) * 16384 + 127) / 255;
    endfunction

    function automatic logic [63:0] clamp_dim(input logic [6:0] d);
        if (d < 1) return 1;
        if (d > MAX_DIM_TB) return MAX_DIM_TB;
        return 64'(d);
    endfunction

    function automatic logic [63:0] texel_coord(input logic [15:0] t, input logic [63:0] dim);
        return (64'(t[11:0]) * (dim - 1) + 2048) >> 12;
    endfunction

    function automatic t_out_item shade_colour(input t_in_item it);
        t_vec3       pos, nin, n, ld, l;
        logic [63:0] c [4];
        logic [63:0] w, h, addr, factor, r;
        logic [31:0] word;
        logic signed [63:0] s, d, q;
        t_out_item   res;
        pos[0] = it.pos_x;    pos[1] = it.pos_y;    pos[2] = it.pos_z;
        nin[0] = it.normal_x; nin[1] = it.normal_y; nin[2] = it.normal_z;
        unit_vector(nin, n);
        if (two_sided) begin
            s = 0;
            for (int i = 0; i < 3; i++)
                s += n[i] * (pos[i] - 64'($signed(camera_pos[16*i +: 16])));
            if (s > 0)
                for (int i = 0; i < 3; i++) n[i] = -n[i];
        end
        if (colour_sel == SRC_DIFFUSE) begin
            for (int i = 0; i < 4; i++) c[i] = byte_to_q14(diffuse_rgba[8*i +: 8]);
        end else if (colour_sel == SRC_TEXTURE) begin
            w    = clamp_dim(tex_w);
            h    = clamp_dim(tex_h);
            addr = texel_coord(it.tex_v, h) * w + texel_coord(it.tex_u, w);
            word = addr < TEX_WORDS_TB ? texels[addr[11:0]] : '0;
            c[0] = 0; c[1] = 0; c[2] = 0; c[3] = 16384;
            if (tex_ch >= 1 && tex_ch <= 4) begin
                c[0] = byte_to_q14(word[7:0]);
                if (tex_ch >= 2) c[1] = byte_to_q14(word[15:8]);
                if (tex_ch >= 3) c[2] = byte_to_q14(word[23:16]);
                if (tex_ch >= 4) c[3] = byte_to_q14(word[31:24]);
            end
        end else begin
            for (int i = 0; i < 4; i++) c[i] = 0;
        end
        for (int i = 0; i < 3; i++)
            ld[i] = 64'($signed(light_pos[16*i +: 16])) - pos[i];
        unit_vector(ld, l);
        d = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
        if (d <= 0) q = 0;
        else begin
            q = (d + 8192) >>> 14;
            if (q > 16384) q = 16384;
        end
        factor = q + 3277;
        r = (factor * c[0] + 8192) >> 14; res.color_red   = r > 65535 ? 16'hFFFF : r[15:0];
        r = (factor * c[1] + 8192) >> 14; res.color_green = r > 65535 ? 16'hFFFF : r[15:0];
        r = (factor * c[2] + 8192) >> 14; res.color_blue  = r > 65535 ? 16'hFFFF : r[15:0];
        res.color_alpha = c[3][14:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            light_pos    <= '0;
            camera_pos   <= '0;
            diffuse_rgba <= 32'hFFFF_FFFF;
            colour_sel   <= SRC_DIFFUSE;
            two_sided    <= 1'b0;
            tex_w        <= 7'd64;
            tex_h        <= 7'd64;
            tex_ch       <= 3'd4;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_colours.size() == 0) begin
                    report_mismatch("unexpected result red", i_out_data.color_red, 16'd0);
                end else begin
                    want = expected_colours.pop_front();
                    if (i_out_data.color_red !== want.color_red)
                        report_mismatch("red", i_out_data.color_red, want.color_red);
                    if (i_out_data.color_green !== want.color_green)
                        report_mismatch("green", i_out_data.color_green, want.color_green);
                    if (i_out_data.color_blue !== want.color_blue)
                        report_mismatch("blue", i_out_data.color_blue, want.color_blue);
                    if (i_out_data.color_alpha !== want.color_alpha)
                        report_mismatch("alpha", 16'(i_out_data.color_alpha),
                                        16'(want.color_alpha));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.opcode == OPC_TEXEL)
                    texels[i_in_data.texel_address] = i_in_data.texel_value;
                else
                    expected_colours.insert(expected_colours.size(),
                                            shade_colour(i_in_data));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LIGHT:    light_pos    <= i_cfg_wdata;
                    CFG_CAMERA:   camera_pos   <= i_cfg_wdata;
                    CFG_DIFFUSE:  diffuse_rgba <= i_cfg_wdata[31:0];
                    CFG_SOURCE:   colour_sel   <= i_cfg_wdata[1:0];
                    CFG_DOUBLE:   two_sided    <= i_cfg_wdata[0];
                    CFG_WIDTH:    tex_w        <= i_cfg_wdata[6:0];
                    CFG_HEIGHT:   tex_h        <= i_cfg_wdata[6:0];
                    CFG_CHANNELS: tex_ch       <= i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### test/diffuse_fragment_shader_textured_tb.sv
`timescale 1ns / 1ps
module diffuse_fragment_shader_textured_tb;
    import dfst_pkg::*;

    localparam int SETTLE = NORM_LAT + 20;
    localparam int STALL_LIMIT = 5000;

    logic        clk, rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    t_in_item    in_data;
    t_out_item   out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_wdata;
    int          pending, errors, burst_left, quiet_cycles, stall_left, stall_mode;
    int          cur_w, cur_h;

    diffuse_fragment_shader_textured dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata)
    );

    dfst_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern
    initial begin
        out_ready  = 1'b0;
        stall_left = 0;
        stall_mode = 0;
    end
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic transfer(input t_in_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid   <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic t_in_item noise_item();
        t_in_item     it;
        logic [191:0] v_bits;
        v_bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = v_bits[$bits(t_in_item)-1:0];
        return it;
    endfunction

    task automatic shade(input logic [15:0] px, py, pz, nx, ny, nz, u, v);
        t_in_item it;
        it = noise_item();
        it.opcode = OPC_SHADE;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.normal_x = nx; it.normal_y = ny; it.normal_z = nz;
        it.tex_u = u; it.tex_v = v;
        transfer(it);
    endtask

    task automatic write_texel(input logic [11:0] addr, input logic [31:0] val);
        t_in_item it;
        it = noise_item();
        it.opcode = OPC_TEXEL;
        it.texel_address = addr;
        it.texel_value = val;
        transfer(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // the enable is dropped after each write, keeping it to one update per step
    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_texture(input int w, input int h);
        cfg_write(CFG_WIDTH, 48'(w));
        cfg_write(CFG_HEIGHT, 48'(h));
        cur_w = (w < 1) ? 1 : (w > 64 ? 64 : w);
        cur_h = (h < 1) ? 1 : (h > 64 ? 64 : h);
        for (int a = 0; a < cur_w * cur_h; a++) write_texel(12'(a), $urandom);
    endtask

    task automatic random_shade();
        logic [15:0] f [8];
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 7))
                0: f[i] = 16'h8000;
                1: f[i] = 16'h7FFF;
                2: f[i] = 16'(int'($urandom_range(0, 64)) - 32);
                default: f[i] = 16'($urandom);
            endcase
        end
        shade(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
    endtask

    initial begin
        int w, h;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_LIGHT;
        cfg_wdata  = '0;
        burst_left = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, white diffuse
        shade(16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        shade(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        shade(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
        shade(16'h0100, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();
        cfg_write(CFG_LIGHT, {16'h0000, 16'h0A00, 16'h0000});
        cfg_write(CFG_CAMERA, {16'h0500, 16'h0000, 16'h0000});
        cfg_write(CFG_DOUBLE, 48'd1);
        cfg_write(CFG_DIFFUSE, 48'h80FF_4000);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000);
        shade(16'h0000, 16'h0A00, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        drain();
        cfg_write(CFG_SOURCE, 48'(SRC_TEXTURE));
        set_texture(4, 3);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'hFFFF, 16'hFFFF);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h7FFF, 16'h8000);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0800, 16'h0C00);
        drain();
        for (int ch = 0; ch < 8; ch++) begin
            cfg_write(CFG_CHANNELS, 48'(ch));
            shade(16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h4000, 16'h0000, 16'h0400, 16'h0400);
            drain();
        end
        cfg_write(CFG_SOURCE, 48'(SRC_EMPTY));
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        drain();
        cfg_write(CFG_SOURCE, 48'd3);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        drain();
        // out-of-range sizes are clamped
        cfg_write(CFG_SOURCE, 48'(SRC_TEXTURE));
        cfg_write(CFG_CHANNELS, 48'd4);
        set_texture(127, 0);
        shade(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0FFF, 16'h0FFF);
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            cfg_write(CFG_LIGHT, 48'({$urandom, $urandom}));
            cfg_write(CFG_CAMERA, 48'({$urandom, $urandom}));
            cfg_write(CFG_DIFFUSE, 48'($urandom));
            cfg_write(CFG_SOURCE, ($urandom_range(0, 9) == 0) ? 48'd3 : 48'($urandom_range(0, 2)));
            cfg_write(CFG_DOUBLE, 48'($urandom_range(0, 1)));
            cfg_write(CFG_CHANNELS,
                      ($urandom_range(0, 5) == 0) ? 48'($urandom_range(0, 7))
                                                  : 48'($urandom_range(1, 4)));
            case (ph % 4)
                0: begin w = 64; h = $urandom_range(1, 2); end
                1: begin w = 1; h = 64; end
                default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
            endcase
            set_texture(w, h);
            for (int k = 0; k < 20; k++) begin
                if ($urandom_range(0, 6) == 0)
                    write_texel(12'($urandom), $urandom);
                else
                    random_shade();
            end
            drain();
        end

        drain();
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
src/dfst_pkg.sv
src/dfst_norm.sv
src/diffuse_fragment_shader_textured.sv
test/dfst_checker.sv
test/diffuse_fragment_shader_textured_tb.sv
